// ----- hw/rtl/cpuf_pkg.sv -----
// cpuf_pkg: shared types and constants for the flagged alu pipeline
package cpuf_pkg;

  // operation codes
  localparam logic [3:0] MODE_ADD  = 4'd0;
  localparam logic [3:0] MODE_ADC  = 4'd1;
  localparam logic [3:0] MODE_SUB  = 4'd2;
  localparam logic [3:0] MODE_SBC  = 4'd3;
  localparam logic [3:0] MODE_ADDW = 4'd4;
  localparam logic [3:0] MODE_SUBW = 4'd5;
  localparam logic [3:0] MODE_NEG  = 4'd6;
  localparam logic [3:0] MODE_INC  = 4'd7;
  localparam logic [3:0] MODE_DEC  = 4'd8;
  localparam logic [3:0] MODE_DIV  = 4'd9;
  localparam logic [3:0] MODE_CPL  = 4'd10;
  localparam logic [3:0] MODE_CP   = 4'd11;
  localparam logic [3:0] MODE_CPW  = 4'd12;

  // flag mask bits
  localparam logic [4:0] MASK_N    = 5'b00001;
  localparam logic [4:0] MASK_Z    = 5'b00010;
  localparam logic [4:0] MASK_H    = 5'b00100;
  localparam logic [4:0] MASK_C    = 5'b01000;
  localparam logic [4:0] MASK_V    = 5'b10000;
  localparam logic [4:0] MASK_NZCV = MASK_N | MASK_Z | MASK_C | MASK_V;
  localparam logic [4:0] MASK_ALL  = MASK_NZCV | MASK_H;

  localparam logic [7:0] SIGN_BYTE = 8'h80;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
    logic        carry_in;
  } op_item_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [7:0]  remainder;
    logic        flag_negative;
    logic        flag_zero;
    logic        flag_half;
    logic        flag_carry;
    logic        flag_overflow;
    logic [4:0]  flags_written;
    logic        divide_error;
  } res_item_t;

  // add/subtract result with flags, already masked
  typedef struct packed {
    logic [15:0] value;
    logic        n;
    logic        z;
    logic        h;
    logic        c;
    logic        v;
    logic [4:0]  mask;
  } alu_res_t;

  // payload carried through the divide stages
  typedef struct packed {
    logic        is_div;
    logic [15:0] dividend;
    logic [7:0]  divisor;
    logic [7:0]  part_rem;
    logic [15:0] quot;
    alu_res_t    alu;
  } pipe_t;

endpackage

// ----- hw/rtl/cpu_alu_with_flags.sv -----
// cpu_alu_with_flags: five-stage alu pipeline with flags and 16-by-8 divider
// pipeline: five register stages, r0, p1, p2, p3 and res, in that order
// throughput: one item per cycle while the output is not stalled; the divider is four stages of four quotient bits
// a stalled output holds each occupied stage that has no empty stage after it; empty stages keep taking data
// reset (synchronous, active high) clears all stage valid bits; no other state
module cpu_alu_with_flags (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_ready,
  input  cpuf_pkg::op_item_t   op,
  output logic                 res_valid,
  input  logic                 res_ready,
  output cpuf_pkg::res_item_t  res
);

  logic v0, v1, v2, v3, v4;
  logic en0, en1, en2, en3, en4;

  cpuf_pkg::op_item_t  r0;
  cpuf_pkg::pipe_t     p1, p2, p3;
  cpuf_pkg::pipe_t     p1_next, p2_next, p3_next;
  cpuf_pkg::res_item_t res_next;
  cpuf_pkg::alu_res_t  alu0;

  logic [7:0] rem1, rem2, rem3, rem4;
  logic [3:0] q1, q2, q3, q4;
  logic [15:0] quot4;

  // stall chain: a stage moves when empty or when the next one moves
  assign en4      = ~v4 | res_ready;
  assign en3      = ~v3 | en4;
  assign en2      = ~v2 | en3;
  assign en1      = ~v1 | en2;
  assign en0      = ~v0 | en1;
  assign op_ready = en0;
  assign res_valid = v4;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en0) v0 <= op_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: flags for add/sub style ops, top quotient nibble
  cpuf_arith u_arith (
    .item (r0),
    .alu  (alu0)
  );

  cpuf_div_step u_div1 (
    .rem_in    (8'd0),
    .bits      (r0.first_operand[15:12]),
    .divisor   (r0.second_operand[7:0]),
    .rem_out   (rem1),
    .quot_bits (q1)
  );

  always_comb begin
    p1_next.is_div   = (r0.mode == cpuf_pkg::MODE_DIV);
    p1_next.dividend = r0.first_operand;
    p1_next.divisor  = r0.second_operand[7:0];
    p1_next.part_rem = rem1;
    p1_next.quot     = {q1, 12'd0};
    p1_next.alu      = alu0;
  end

  // stage 2: next quotient nibble
  cpuf_div_step u_div2 (
    .rem_in    (p1.part_rem),
    .bits      (p1.dividend[11:8]),
    .divisor   (p1.divisor),
    .rem_out   (rem2),
    .quot_bits (q2)
  );

  always_comb begin
    p2_next          = p1;
    p2_next.part_rem = rem2;
    p2_next.quot     = {p1.quot[15:12], q2, 8'd0};
  end

  // stage 3: next quotient nibble
  cpuf_div_step u_div3 (
    .rem_in    (p2.part_rem),
    .bits      (p2.dividend[7:4]),
    .divisor   (p2.divisor),
    .rem_out   (rem3),
    .quot_bits (q3)
  );

  always_comb begin
    p3_next          = p2;
    p3_next.part_rem = rem3;
    p3_next.quot     = {p2.quot[15:8], q3, 4'd0};
  end

  // stage 4: last quotient nibble and result assembly
  cpuf_div_step u_div4 (
    .rem_in    (p3.part_rem),
    .bits      (p3.dividend[3:0]),
    .divisor   (p3.divisor),
    .rem_out   (rem4),
    .quot_bits (q4)
  );

  assign quot4 = {p3.quot[15:4], q4};

  always_comb begin
    res_next.result_value  = p3.alu.value;
    res_next.remainder     = 8'd0;
    res_next.flag_negative = p3.alu.n;
    res_next.flag_zero     = p3.alu.z;
    res_next.flag_half     = p3.alu.h;
    res_next.flag_carry    = p3.alu.c;
    res_next.flag_overflow = p3.alu.v;
    res_next.flags_written = p3.alu.mask;
    res_next.divide_error  = 1'b0;
    if (p3.is_div) begin
      res_next.flag_negative = 1'b0;
      res_next.flag_half     = 1'b0;
      res_next.flag_overflow = 1'b0;
      if (p3.divisor == 8'd0) begin
        // zero divisor: operands pass through, carry and error set
        res_next.result_value  = p3.dividend;
        res_next.remainder     = p3.divisor;
        res_next.flag_zero     = 1'b0;
        res_next.flag_carry    = 1'b1;
        res_next.flags_written = cpuf_pkg::MASK_C;
        res_next.divide_error  = 1'b1;
      end else begin
        res_next.result_value  = quot4;
        res_next.remainder     = rem4;
        res_next.flag_zero     = (quot4 == 16'd0);
        res_next.flag_carry    = 1'b0;
        res_next.flags_written = cpuf_pkg::MASK_ALL;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en0 && op_valid) r0 <= op;
    if (en1 && v0) p1 <= p1_next;
    if (en2 && v1) p2 <= p2_next;
    if (en3 && v2) p3 <= p3_next;
    if (en4 && v3) res <= res_next;
  end

endmodule

// ----- hw/rtl/cpuf_arith.sv -----
// cpuf_arith: adder/subtracter with flag generation for all non-divide operations
module cpuf_arith (
  input  cpuf_pkg::op_item_t item,
  output cpuf_pkg::alu_res_t alu
);

  logic        width8;
  logic        do_sub;
  logic [16:0] a;
  logic [16:0] m;
  logic [16:0] ci;
  logic [16:0] s;
  logic [16:0] x;
  logic [15:0] r;
  logic        nf, zf, hf, cf, vf;
  logic [4:0]  mask;
  logic [7:0]  a8;
  logic [7:0]  m8;

  assign a8 = item.first_operand[7:0];
  assign m8 = item.second_operand[7:0];

  // operand selection
  always_comb begin
    width8 = 1'b1;
    do_sub = 1'b0;
    a      = {9'd0, a8};
    m      = {9'd0, m8};
    ci     = 17'd0;
    unique case (item.mode) inside
      cpuf_pkg::MODE_ADC: ci = {16'd0, item.carry_in};
      cpuf_pkg::MODE_SUB, cpuf_pkg::MODE_CP: do_sub = 1'b1;
      cpuf_pkg::MODE_SBC: begin
        do_sub = 1'b1;
        ci     = {16'd0, item.carry_in};
      end
      cpuf_pkg::MODE_ADDW: begin
        width8 = 1'b0;
        a      = {1'b0, item.first_operand};
        m      = {1'b0, item.second_operand};
      end
      cpuf_pkg::MODE_SUBW, cpuf_pkg::MODE_CPW: begin
        width8 = 1'b0;
        do_sub = 1'b1;
        a      = {1'b0, item.first_operand};
        m      = {1'b0, item.second_operand};
      end
      cpuf_pkg::MODE_NEG: begin
        do_sub = 1'b1;
        a      = 17'd0;
        m      = {9'd0, a8};
      end
      cpuf_pkg::MODE_INC: m = 17'd1;
      cpuf_pkg::MODE_DEC: begin
        do_sub = 1'b1;
        m      = 17'd1;
      end
      default: ;
    endcase
  end

  // sum and carry into each bit
  assign s = do_sub ? (a - m - ci) : (a + m + ci);
  assign x = a ^ m ^ s;

  // flags per operation
  always_comb begin
    r    = width8 ? {8'd0, s[7:0]} : s[15:0];
    nf   = width8 ? s[7] : s[15];
    zf   = (r == 16'd0);
    hf   = width8 ? x[4] : x[8];
    cf   = width8 ? x[8] : x[16];
    vf   = width8 ? (x[8] ^ x[7]) : (x[16] ^ x[15]);
    mask = 5'd0;
    unique case (item.mode) inside
      cpuf_pkg::MODE_ADD, cpuf_pkg::MODE_ADC,
      cpuf_pkg::MODE_ADDW, cpuf_pkg::MODE_SUBW: mask = cpuf_pkg::MASK_ALL;
      cpuf_pkg::MODE_SUB, cpuf_pkg::MODE_SBC,
      cpuf_pkg::MODE_CP, cpuf_pkg::MODE_CPW: mask = cpuf_pkg::MASK_NZCV;
      cpuf_pkg::MODE_NEG: begin
        cf   = ~zf;
        vf   = (s[7:0] == cpuf_pkg::SIGN_BYTE);
        mask = cpuf_pkg::MASK_NZCV;
      end
      cpuf_pkg::MODE_INC, cpuf_pkg::MODE_DEC:
        mask = cpuf_pkg::MASK_N | cpuf_pkg::MASK_Z | cpuf_pkg::MASK_V;
      cpuf_pkg::MODE_CPL: begin
        r    = {8'd0, cpuf_pkg::BYTE_MASK ^ a8};
        nf   = ~a8[7];
        zf   = (a8 == cpuf_pkg::BYTE_MASK);
        cf   = 1'b1;
        mask = cpuf_pkg::MASK_N | cpuf_pkg::MASK_Z | cpuf_pkg::MASK_C;
      end
      default: r = 16'd0;
    endcase
  end

  // unwritten flags read as zero
  assign alu.value = (mask == 5'd0) ? 16'd0 : r;
  assign alu.n     = nf & mask[0];
  assign alu.z     = zf & mask[1];
  assign alu.h     = hf & mask[2];
  assign alu.c     = cf & mask[3];
  assign alu.v     = vf & mask[4];
  assign alu.mask  = mask;

endmodule

// ----- hw/rtl/cpuf_div_step.sv -----
// cpuf_div_step: four restoring division steps, one quotient bit each
module cpuf_div_step (
  input  logic [7:0] rem_in,
  input  logic [3:0] bits,
  input  logic [7:0] divisor,
  output logic [7:0] rem_out,
  output logic [3:0] quot_bits
);

  logic [7:0] r;
  logic [8:0] t;

  // shift in one dividend bit, subtract divisor when it fits
  always_comb begin
    r         = rem_in;
    t         = 9'd0;
    quot_bits = 4'd0;
    for (int k = 0; k < 4; k++) begin
      t = {r, bits[2'(3 - k)]};
      if (t >= {1'b0, divisor}) begin
        r                      = 8'(t - {1'b0, divisor});
        quot_bits[2'(3 - k)]   = 1'b1;
      end else begin
        r = t[7:0];
      end
    end
    rem_out = r;
  end

endmodule
